// ----- design/assert_macros.svh -----
// Assertion macros for the heap sorter top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/hs_pkg.sv -----
// Types and constants for the heap sorter.
// No dependencies.
package hs_pkg;

   typedef struct packed {
      logic [63:0] value;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] value_res;
      logic        last_res;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] value;
   } slot_type;

   // Sign-magnitude ordering key of a double bit pattern.
   function automatic logic [63:0] order_key(input logic [63:0] b);
      logic [63:0] k;
      k = b[63] ? ~b : (b | 64'h8000_0000_0000_0000);
      return k;
   endfunction

endpackage

// ----- design/hs_cell.sv -----
// One cell of the sorting chain: keeps the smaller of what it holds and what
// arrives, and hands the larger on. Depends on hs_pkg.
module hs_cell
   import hs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     clear,
   input  logic     shift,
   input  slot_type din,
   input  slot_type lower,
   output slot_type dout,
   output slot_type held
);
   slot_type held_ff, held_in;
   slot_type pass_ff, pass_in;
   logic     arrive_wins;

   assign arrive_wins = din.valid &&
      (!held_ff.valid || order_key(din.value) < order_key(held_ff.value));

   always_comb begin
      held_in = held_ff;
      pass_in = pass_ff;
      if (clear) begin
         held_in = '0;
         pass_in = '0;
      end else if (shift) begin
         // shift mode: chain moves up one cell, nothing passes down
         held_in = lower;
         pass_in = '0;
      end else if (arrive_wins) begin
         held_in = din;
         pass_in = held_ff;
      end else begin
         pass_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         pass_ff.valid <= pass_in.valid;
      end
      held_ff.value <= held_in.value;
      pass_ff.value <= pass_in.value;
   end

   assign dout = pass_ff;
   assign held = held_ff;
endmodule

// ----- design/heap_sorter_top.sv -----
// Heap sorter top level: load chain of compare cells, then drain in order.
// Depends on hs_pkg, hs_cell, assert_macros.svh.
//
//  channel  | dir | handshake
//  req      | in  | req_valid / req_ready, payload req_data
//  rsp      | out | rsp_valid / rsp_ready, payload rsp_data
//
// Each item enters the cell chain as it is accepted; after the last item the
// chain settles in SETTLE, then drains one result per cycle while rsp_ready
// is high from the top cell, smallest first.
// Stalls on rsp hold the chain. Reset is synchronous and clears control.
`include "assert_macros.svh"
module heap_sorter_top
   import hs_pkg::*;
#(
   parameter int DEPTH = 64
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      LOAD   = 3'b001,
      SETTLE = 3'b010,
      DRAIN  = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   slot_type       link [DEPTH+1];
   slot_type       held [DEPTH];
   logic           shift, clear, accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == LOAD);
   // drain: top cell shows smallest; shifting moves the next one up
   assign rsp_valid = (state_ff == DRAIN);
   assign rsp_data.value_res = held[DEPTH-1].value;
   assign rsp_data.last_res  = (cnt_ff == CW'(1));
   assign shift = (state_ff == DRAIN) && rsp_ready;
   assign clear = 1'b0;

   // input enters at the top and larger values sink towards cell 0
   assign link[DEPTH].valid = accept && (fill_ff < CW'(DEPTH));
   assign link[DEPTH].value = req_data.value;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         slot_type dout;
         slot_type lower;
         hs_cell u_cell (
            .clock(clock), .reset(reset), .clear(clear), .shift(shift),
            .din(g == DEPTH - 1 ? link[DEPTH] : link[g+1]),
            .lower(lower),
            .dout(dout), .held(held[g])
         );
         if (g > 0) begin : g_lk
            assign link[g] = dout;
            assign lower   = held[g-1];
         end else begin : g_l0
            assign link[0] = dout;
            assign lower   = '0;
         end
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         LOAD: begin
            if (accept) begin
               if (fill_ff < CW'(DEPTH)) fill_in = fill_ff + CW'(1);
               if (req_data.last) begin
                  state_in = SETTLE;
                  cnt_in   = CW'(DEPTH);
               end
            end
         end
         SETTLE: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = DRAIN;
               cnt_in   = fill_ff;
            end
         end
         DRAIN: begin
            if (rsp_ready) begin
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = LOAD;
                  fill_in  = '0;
               end
            end
         end
         default: state_in = LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         fill_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
      end
   end

   `HS_ASSERT_IMPL(a_rsp_held, rsp_valid, held[DEPTH-1].valid, "drain shows empty cell")
   `HS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= CW'(DEPTH), "fill beyond depth")
   `HS_ASSERT_NEXT(a_last_done, rsp_valid && rsp_ready && rsp_data.last_res,
      state_ff == LOAD, "no return to load after final item")
endmodule
